>>> rtl/obl_pkg.sv
// ----------------------------------------------------------------------------
// obl_pkg: shared types and constants for the octave band level block
// Record and result layouts, divider handshake and register indexes.
// ----------------------------------------------------------------------------
package obl_pkg;

    localparam int MAG_W       = 16;
    localparam int ACC_W       = 24;
    localparam int CNT_W       = 12;
    localparam int LVL_W       = 12;
    localparam int BAND_W      = 4;
    localparam int MAX_BANDS   = 16;
    localparam int LOUD_W      = 8;
    localparam int SUM_W       = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int DVD_W       = 24;
    localparam int DSR_W       = 12;
    localparam int TDATA_W     = 48;
    localparam int IN_TDATA_W  = 16;

    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_PEAK_DECAY     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOUDNESS_FLOOR = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BIN_THRESHOLD  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BEAT_THRESHOLD = 2'd3;

    localparam logic [7:0]  RST_PEAK_DECAY     = 8'd1;
    localparam logic [7:0]  RST_LOUDNESS_FLOOR = 8'd0;
    localparam logic [15:0] RST_BIN_THRESHOLD  = 16'd1500;
    localparam logic [11:0] RST_BEAT_THRESHOLD = 12'd30;

    // one finished band, handed from front to back
    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [ACC_W-1:0]  acc;
        logic [CNT_W-1:0]  cnt;
        logic              done;
    } band_rec_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [7:0]  peak_decay;
        logic [7:0]  loudness_floor;
        logic [11:0] beat_threshold;
    } back_cfg_t;

    typedef struct packed {
        logic [BAND_W-1:0] band_number;
        logic [LVL_W-1:0]  band_level;
        logic [LVL_W-1:0]  band_peak;
        logic              peak_new;
        logic              frame_done;
        logic [LOUD_W-1:0] loudness_scaled;
        logic [LOUD_W-1:0] loudness_smooth;
        logic              beat_flag;
    } result_t;

endpackage

>>> rtl/octave_band_level_peak_loudness.sv
// ----------------------------------------------------------------------------
// octave_band_level_peak_loudness: octave band levels, peaks and loudness
// Bin stream in, one result beat per octave band, frame loudness on the last.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel: one FFT magnitude bin per beat, FFT_POINTS/2 bins per frame,
//    bins in ascending order; the bin index is counted inside.
//  - m_ channel: one beat per band; tlast marks the last band of the frame,
//    which also carries loudness, smoothed loudness and the beat flag.
//  - Config: cfg_we/cfg_addr/cfg_wdata, written while the block is idle.
//  - Front takes one bin per cycle while the 4-entry band queue has room.
//  - Back runs a shared 2-bit-per-cycle divider, one band at a time: at most
//    one division per band, up to four for the last band (level, mean,
//    scaled loudness, beat); NB = floor(log2(FFT_POINTS))-1 bands.
//  - Reset (aresetn low, synchronous) clears counters, peaks and loudness
//    state and restores register defaults.
//  - A stalled m_tready holds the result beat; the back keeps working on the
//    next queued band, and s_tready drops only when the queue is full.
// ----------------------------------------------------------------------------
module octave_band_level_peak_loudness import obl_pkg::*; #(
    parameter int FFT_POINTS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // [15:0] bin_magnitude
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] band_number, [15:4] band_level, [27:16] band_peak, [28] peak_new,
    // [36:29] loudness_scaled, [44:37] loudness_smooth, [45] beat_flag, [47:46] 0
    output logic [TDATA_W-1:0]    m_tdata,
    output logic                  m_tlast,   // frame_done
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [7:0]  peak_decay_reg;
    logic [7:0]  loudness_floor_reg;
    logic [15:0] bin_threshold_reg;
    logic [11:0] beat_threshold_reg;

    logic        bin_accept;
    logic        rec_push, fifo_full, fifo_empty, rec_pop;
    band_rec_t   rec_in, rec_head;
    back_cfg_t   back_cfg;
    result_t     res;

    // register file: plain writes, out-of-range cannot occur on 2 address bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_decay_reg     <= RST_PEAK_DECAY;
            loudness_floor_reg <= RST_LOUDNESS_FLOOR;
            bin_threshold_reg  <= RST_BIN_THRESHOLD;
            beat_threshold_reg <= RST_BEAT_THRESHOLD;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_PEAK_DECAY:     peak_decay_reg     <= cfg_wdata[7:0];
                REG_LOUDNESS_FLOOR: loudness_floor_reg <= cfg_wdata[7:0];
                REG_BIN_THRESHOLD:  bin_threshold_reg  <= cfg_wdata[15:0];
                REG_BEAT_THRESHOLD: beat_threshold_reg <= cfg_wdata[11:0];
            endcase
        end
    end

    // a bin beat is taken whenever the band queue has a free entry
    assign s_tready   = !fifo_full;
    assign bin_accept = s_tvalid && s_tready;

    assign back_cfg.peak_decay     = peak_decay_reg;
    assign back_cfg.loudness_floor = loudness_floor_reg;
    assign back_cfg.beat_threshold = beat_threshold_reg;

    obl_front #(
        .FFT_POINTS (FFT_POINTS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .bin_accept    (bin_accept),
        .bin_magnitude (s_tdata[MAG_W-1:0]),
        .bin_threshold (bin_threshold_reg),
        .rec_push      (rec_push),
        .rec           (rec_in)
    );

    // closed bands wait here for the divider-based back part
    obl_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (rec_push),
        .push_rec (rec_in),
        .pop      (rec_pop),
        .head     (rec_head),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    obl_back #(
        .FFT_POINTS (FFT_POINTS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (back_cfg),
        .head       (rec_head),
        .fifo_empty (fifo_empty),
        .pop        (rec_pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .res        (res)
    );

    // pack result fields, lowest field first
    assign m_tdata = {2'b00, res.beat_flag, res.loudness_smooth, res.loudness_scaled,
                      res.peak_new, res.band_peak, res.band_level, res.band_number};
    assign m_tlast = res.frame_done;

endmodule

>>> rtl/obl_front.sv
// ----------------------------------------------------------------------------
// obl_front: bin counting and band accumulation
// Counts bins in a frame, sums qualifying magnitudes over 16 and closes bands.
// ----------------------------------------------------------------------------
module obl_front import obl_pkg::*; #(
    parameter int FFT_POINTS = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              bin_accept,
    input  logic [MAG_W-1:0]  bin_magnitude,
    input  logic [15:0]       bin_threshold,
    output logic              rec_push,
    output band_rec_t         rec
);

    localparam int FRAME_LEN = FFT_POINTS / 2;
    localparam int BIN_W     = $clog2(FRAME_LEN);
    localparam int LAST      = FRAME_LEN - 1;
    localparam int NB        = $clog2(FFT_POINTS + 1) - 2;

    logic [BIN_W-1:0]  bin_reg, end_reg;
    logic [BAND_W-1:0] band_reg;
    logic [ACC_W-1:0]  acc_reg, acc_sum;
    logic [CNT_W-1:0]  cnt_reg, cnt_sum;
    logic              active, qual, emit, wrap;
    logic [BIN_W:0]    end_dbl;
    logic [BIN_W-1:0]  end_next;

    always_comb begin
        active   = (bin_reg >= BIN_W'(2)) && (band_reg < BAND_W'(NB));
        qual     = bin_magnitude > bin_threshold;
        acc_sum  = acc_reg + (qual ? ACC_W'(bin_magnitude[MAG_W-1:4]) : '0);
        cnt_sum  = cnt_reg + CNT_W'(qual);
        emit     = active && (bin_reg >= end_reg);
        wrap     = bin_reg == BIN_W'(LAST);
        // next band ends at twice this one, cut at the frame's last bin
        end_dbl  = {end_reg, 1'b0};
        end_next = (end_dbl > (BIN_W+1)'(LAST)) ? BIN_W'(LAST) : end_dbl[BIN_W-1:0];
    end

    assign rec_push  = bin_accept && emit;
    assign rec.band  = band_reg;
    assign rec.acc   = acc_sum;
    assign rec.cnt   = cnt_sum;
    assign rec.done  = band_reg == BAND_W'(NB - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_reg  <= '0;
            band_reg <= '0;
            end_reg  <= BIN_W'(2);
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end else if (bin_accept) begin
            if (wrap) begin
                bin_reg  <= '0;
                band_reg <= '0;
                end_reg  <= BIN_W'(2);
                acc_reg  <= '0;
                cnt_reg  <= '0;
            end else begin
                bin_reg <= bin_reg + BIN_W'(1);
                if (emit) begin
                    acc_reg  <= '0;
                    cnt_reg  <= '0;
                    band_reg <= band_reg + BAND_W'(1);
                    end_reg  <= end_next;
                end else if (active) begin
                    acc_reg <= acc_sum;
                    cnt_reg <= cnt_sum;
                end
            end
        end
    end

endmodule

>>> rtl/obl_fifo.sv
// ----------------------------------------------------------------------------
// obl_fifo: band record queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module obl_fifo import obl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  band_rec_t push_rec,
    input  logic      pop,
    output band_rec_t head,
    output logic      full,
    output logic      empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    band_rec_t       mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg;

    assign full  = cnt_reg == CW'(QUEUE_DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + AW'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

endmodule

>>> rtl/obl_div.sv
// ----------------------------------------------------------------------------
// obl_div: iterative unsigned divider
// Restoring division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module obl_div import obl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEPS = DVD_W / 2;
    localparam int CW    = $clog2(STEPS);

    logic             busy_reg, done_reg;
    logic [CW-1:0]    step_reg;
    logic [DSR_W-1:0] rem_reg, dsr_reg;
    logic [DVD_W-1:0] dvd_reg;

    logic [DSR_W:0]   r1, r2, d_ext, r1_sub, r2_sub;
    logic             ge1, ge2;
    logic [DSR_W-1:0] rem1, rem2;

    always_comb begin
        d_ext  = {1'b0, dsr_reg};
        r1     = {rem_reg, dvd_reg[DVD_W-1]};
        ge1    = r1 >= d_ext;
        r1_sub = r1 - d_ext;
        rem1   = ge1 ? r1_sub[DSR_W-1:0] : r1[DSR_W-1:0];
        r2     = {rem1, dvd_reg[DVD_W-2]};
        ge2    = r2 >= d_ext;
        r2_sub = r2 - d_ext;
        rem2   = ge2 ? r2_sub[DSR_W-1:0] : r2[DSR_W-1:0];
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + CW'(1);
                if (step_reg == CW'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in where dividend bits leave
    always_ff @(posedge aclk) begin
        if (req.start && !busy_reg) begin
            rem_reg <= '0;
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem2;
            dvd_reg <= {dvd_reg[DVD_W-3:0], ge1, ge2};
        end
    end

endmodule

>>> rtl/obl_back.sv
// ----------------------------------------------------------------------------
// obl_back: band level, peak hold and frame loudness
// Sequences the divisions per band and per frame, holds the result beat.
// ----------------------------------------------------------------------------
module obl_back import obl_pkg::*; #(
    parameter int FFT_POINTS = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  back_cfg_t cfg,
    input  band_rec_t head,
    input  logic      fifo_empty,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output result_t   res
);

    localparam int NB      = $clog2(FFT_POINTS + 1) - 2;
    localparam int LOW_CNT = (NB > 7) ? NB - 7 : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_LEVEL, S_PEAK, S_MEAN, S_LMAX, S_SCALE, S_SMOOTH, S_BEAT, S_EMIT
    } state_t;

    state_t            state_reg;
    band_rec_t         rec_reg;
    logic [LVL_W-1:0]  level_reg, mean_reg, lmax_reg, pk_out_reg;
    logic [SUM_W-1:0]  level_sum_reg, low_sum_reg;
    logic [LOUD_W-1:0] sm_reg, ls_reg, sm_out_reg;
    logic              beat_reg, new_reg, m_valid_reg;
    result_t           res_reg;
    logic [LVL_W-1:0]  peak_mem [MAX_BANDS];

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic [LVL_W-1:0]  pk_old, pk_n, blend, lmax_n;
    logic              pk_new;
    logic [SUM_W-1:0]  level_sum_n, low_sum_n;
    logic [LVL_W:0]    lmax_sum;
    logic [19:0]       scale_num;
    logic [LOUD_W-1:0] ls_clamp, sm_n;
    logic [LOUD_W:0]   sm_sum;
    logic              can_emit;

    obl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        pk_old = peak_mem[rec_reg.band];
        pk_new = 1'b0;
        if (pk_old < level_reg) begin
            pk_n   = level_reg;
            pk_new = 1'b1;
        end else if ({4'b0, cfg.peak_decay} <= pk_old) begin
            pk_n = pk_old - {4'b0, cfg.peak_decay};
        end else begin
            pk_n = '0;
        end

        level_sum_n = level_sum_reg + SUM_W'(level_reg);
        low_sum_n   = (rec_reg.band < BAND_W'(LOW_CNT)) ?
                      low_sum_reg + SUM_W'(level_reg) : low_sum_reg;

        blend    = (mean_reg > {4'b0, cfg.loudness_floor}) ? mean_reg
                                                           : {4'b0, cfg.loudness_floor};
        lmax_sum = {1'b0, lmax_reg} + {1'b0, blend};
        lmax_n   = (lmax_reg < mean_reg) ? mean_reg : lmax_sum[LVL_W:1];

        // mean * 255
        scale_num = {mean_reg, 8'b0} - {8'b0, mean_reg};
        ls_clamp  = (div_rsp.quotient > DVD_W'(255)) ? 8'hFF : div_rsp.quotient[7:0];

        sm_sum = {1'b0, sm_reg} + {1'b0, ls_reg};
        sm_n   = (sm_reg > 8'd2 || ls_reg != '0) ? sm_sum[LOUD_W:1] : '0;

        pop      = (state_reg == S_IDLE) && !fifo_empty;
        can_emit = !m_valid_reg || m_ready;
    end

    always_comb begin
        div_req = '0;
        case (state_reg)
            S_IDLE: begin
                if (pop && head.acc != '0 && head.cnt != '0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = head.acc;
                    div_req.divisor  = head.cnt;
                end
            end
            S_PEAK: begin
                if (rec_reg.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(level_sum_n);
                    div_req.divisor  = DSR_W'(NB);
                end
            end
            S_LMAX: begin
                if (lmax_n != '0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DVD_W'(scale_num);
                    div_req.divisor  = lmax_n;
                end
            end
            S_SMOOTH: begin
                div_req.start    = 1'b1;
                div_req.dividend = DVD_W'(low_sum_reg);
                div_req.divisor  = DSR_W'(LOW_CNT);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_BANDS; i++) begin
                peak_mem[i] <= '0;
            end
        end else if (state_reg == S_PEAK) begin
            peak_mem[rec_reg.band] <= pk_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            level_sum_reg <= '0;
            low_sum_reg   <= '0;
            lmax_reg      <= '0;
            sm_reg        <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (pop) begin
                        rec_reg    <= head;
                        ls_reg     <= '0;
                        sm_out_reg <= '0;
                        beat_reg   <= 1'b0;
                        if (head.acc != '0 && head.cnt != '0) begin
                            state_reg <= S_LEVEL;
                        end else begin
                            level_reg <= '0;
                            state_reg <= S_PEAK;
                        end
                    end
                end
                S_LEVEL: begin
                    if (div_rsp.done) begin
                        level_reg <= div_rsp.quotient[LVL_W-1:0];
                        state_reg <= S_PEAK;
                    end
                end
                S_PEAK: begin
                    pk_out_reg    <= pk_n;
                    new_reg       <= pk_new;
                    level_sum_reg <= level_sum_n;
                    low_sum_reg   <= low_sum_n;
                    state_reg     <= rec_reg.done ? S_MEAN : S_EMIT;
                end
                S_MEAN: begin
                    if (div_rsp.done) begin
                        mean_reg  <= div_rsp.quotient[LVL_W-1:0];
                        state_reg <= S_LMAX;
                    end
                end
                S_LMAX: begin
                    lmax_reg <= lmax_n;
                    if (lmax_n != '0) begin
                        state_reg <= S_SCALE;
                    end else begin
                        // zero maximum: loudness stays 0
                        ls_reg    <= '0;
                        state_reg <= S_SMOOTH;
                    end
                end
                S_SCALE: begin
                    if (div_rsp.done) begin
                        ls_reg    <= ls_clamp;
                        state_reg <= S_SMOOTH;
                    end
                end
                S_SMOOTH: begin
                    sm_reg     <= sm_n;
                    sm_out_reg <= sm_n;
                    state_reg  <= S_BEAT;
                end
                S_BEAT: begin
                    if (div_rsp.done) begin
                        beat_reg      <= div_rsp.quotient > DVD_W'(cfg.beat_threshold);
                        level_sum_reg <= '0;
                        low_sum_reg   <= '0;
                        state_reg     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (can_emit) begin
                        res_reg.band_number     <= rec_reg.band;
                        res_reg.band_level      <= level_reg;
                        res_reg.band_peak       <= pk_out_reg;
                        res_reg.peak_new        <= new_reg;
                        res_reg.frame_done      <= rec_reg.done;
                        res_reg.loudness_scaled <= ls_reg;
                        res_reg.loudness_smooth <= sm_out_reg;
                        res_reg.beat_flag       <= beat_reg;
                        m_valid_reg             <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign res     = res_reg;

`ifndef SYNTHESIS
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_LEVEL || state_reg == S_MEAN ||
                          state_reg == S_SCALE || state_reg == S_BEAT))
        else $error("divider result with no state waiting for it");

    a_pop_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> state_reg != S_IDLE)
        else $error("record popped but sequencer stayed idle");

    a_frame_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_reg.frame_done) |->
        (res_reg.loudness_scaled == '0 && res_reg.loudness_smooth == '0 &&
         !res_reg.beat_flag))
        else $error("frame fields set on a band that does not end the frame");
`endif

endmodule

>>> tb/sv/octave_band_level_peak_loudness_test.sv
// ----------------------------------------------------------------------------
// octave_band_level_peak_loudness_test: self-checking bench for the band block
// Streams FFT bins through the block and checks every band beat against a
// cycle-free model or hand-typed values. A short directed table comes first.
// Random frames then run under several config settings, idle and stall
// patterns and one long output hold.
// ----------------------------------------------------------------------------
module octave_band_level_peak_loudness_test;
    timeunit 1ns;
    timeprecision 1ps;
    import obl_pkg::*;

    localparam int FFT_POINTS     = 64;
    localparam int FRAME_BINS     = FFT_POINTS / 2;
    // floor(log2(FFT_POINTS)) - 1 octave bands
    localparam int NUM_BANDS      = $clog2(FFT_POINTS + 1) - 2;
    // bands averaged for the beat flag
    localparam int BASS_BANDS     = (NUM_BANDS > 7) ? NUM_BANDS - 7 : 1;
    // settle time after the last band beat, with margin; used before config writes
    localparam int SETTLE_CYCLES  = 100;
    localparam int HOLD_CYCLES    = 400;
    // longest legal quiet stretch is the output hold; several times over
    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum logic {ROW_BIN, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [15:0]           value;   // bin magnitude or register value
        int                    reps;    // bins repeated with the same value
        bit                    typed;   // use want instead of the model
        result_t               want;
    } dir_row_t;

    // DUT ports
    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // model copy of the registers
    logic [7:0]  cfg_decay    = RST_PEAK_DECAY;
    logic [7:0]  cfg_floor    = RST_LOUDNESS_FLOOR;
    logic [15:0] cfg_bin_thr  = RST_BIN_THRESHOLD;
    logic [11:0] cfg_beat_thr = RST_BEAT_THRESHOLD;

    // model state, cleared as by reset
    logic [11:0] bin_idx         = '0;
    logic [3:0]  band_idx        = '0;
    logic [23:0] band_sum        = '0;
    logic [11:0] band_hits       = '0;
    logic [11:0] peak_hold [MAX_BANDS] = '{default: '0};
    logic [15:0] frame_level_sum = '0;
    logic [15:0] bass_level_sum  = '0;
    logic [11:0] loud_max        = '0;
    logic [7:0]  loud_smooth     = '0;

    result_t     band_results_due[$];   // predicted band beats, oldest first

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;             // bumped by stimulus, served by sink
    int frame_shift    = 0;             // loudness of the current random frame

    int mismatches     = 0;
    int bins_sent      = 0;
    int bands_checked  = 0;
    int frames_seen    = 0;
    int beats_seen     = 0;
    int new_peaks      = 0;

    octave_band_level_peak_loudness #(
        .FFT_POINTS(FFT_POINTS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // [15:0] bin_magnitude
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // band, level, peak, new, scaled, smooth, beat
        .m_tlast  (m_tlast),     // frame_done
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Band model: one accepted bin in, at most one band beat out.
    // ------------------------------------------------------------------------
    function automatic bit octave_step(input logic [15:0] mag, output result_t r);
        int unsigned k, b, last, lvl, pk, mean, blend, scaled;
        bit emit;
        k    = bin_idx;
        b    = band_idx;
        emit = 1'b0;
        r    = '0;
        // bins 0 and 1 never count; bins past the last band only advance
        if (k >= 2 && b < NUM_BANDS) begin
            if (mag > cfg_bin_thr) begin
                band_sum  = band_sum + (mag >> 4);
                band_hits = band_hits + 12'd1;
            end
            last = 2 << b;
            if (last > FRAME_BINS - 1)
                last = FRAME_BINS - 1;
            if (k >= last) begin
                lvl = 0;
                if (band_sum != 0 && band_hits != 0)
                    lvl = (band_sum / band_hits) & 32'hFFF;
                pk = peak_hold[b];
                if (pk < lvl) begin
                    pk = lvl;
                    r.peak_new = 1'b1;
                end else if (cfg_decay <= pk) begin
                    pk = pk - cfg_decay;
                end else begin
                    pk = 0;     // decay floors at zero
                end
                peak_hold[b]    = pk[11:0];
                frame_level_sum = frame_level_sum + lvl;
                if (b < BASS_BANDS)
                    bass_level_sum = bass_level_sum + lvl;
                r.band_number = b[3:0];
                r.band_level  = lvl[11:0];
                r.band_peak   = pk[11:0];
                if (b + 1 >= NUM_BANDS) begin
                    r.frame_done = 1'b1;
                    mean = (frame_level_sum / NUM_BANDS) & 32'hFFF;
                    if (loud_max < mean) begin
                        loud_max = mean[11:0];
                    end else begin
                        blend    = (mean > cfg_floor) ? mean : cfg_floor;
                        loud_max = 12'((loud_max + blend) / 2);
                    end
                    // zero maximum gives zero loudness instead of a divide
                    scaled = 0;
                    if (loud_max != 0) begin
                        scaled = (mean * 255) / loud_max;
                        if (scaled > 255)
                            scaled = 255;
                    end
                    if (loud_smooth > 2 || scaled != 0)
                        loud_smooth = 8'((loud_smooth + scaled) / 2);
                    else
                        loud_smooth = '0;
                    r.loudness_scaled = scaled[7:0];
                    r.loudness_smooth = loud_smooth;
                    r.beat_flag       = (bass_level_sum / BASS_BANDS) > cfg_beat_thr;
                    frame_level_sum   = '0;
                    bass_level_sum    = '0;
                end
                band_sum  = '0;
                band_hits = '0;
                band_idx  = band_idx + 4'd1;
                emit      = 1'b1;
            end
        end
        // frame wrap
        if (k + 1 >= FRAME_BINS) begin
            bin_idx         = '0;
            band_idx        = '0;
            band_sum        = '0;
            band_hits       = '0;
            frame_level_sum = '0;
            bass_level_sum  = '0;
        end else begin
            bin_idx = 12'(k + 1);
        end
        return emit;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic dir_row_t bin_row(input logic [15:0] mag, input int reps);
        dir_row_t r;
        r.kind  = ROW_BIN;
        r.addr  = '0;
        r.value = mag;
        r.reps  = reps;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // expected beat typed in by hand; loudness fields are zero in all of these
    function automatic dir_row_t checked_row(input logic [15:0] mag, input int reps,
                                             input int band, input int lvl, input int pk,
                                             input bit isnew, input bit done);
        dir_row_t r;
        r                  = bin_row(mag, reps);
        r.typed            = 1'b1;
        r.want.band_number = band[3:0];
        r.want.band_level  = lvl[11:0];
        r.want.band_peak   = pk[11:0];
        r.want.peak_new    = isnew;
        r.want.frame_done  = done;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_ADDR_W-1:0] addr,
                                         input logic [15:0] value);
        dir_row_t r;
        r       = bin_row(value, 1);
        r.kind  = ROW_CFG;
        r.addr  = addr;
        return r;
    endfunction

    // random bin: loudness picked per frame, with zeros, full scale and
    // values right around the bin threshold mixed in
    function automatic logic [15:0] rand_mag();
        int unsigned pick;
        logic [15:0] mag;
        if (bin_idx == 0)
            frame_shift = $urandom_range(16);
        pick = $urandom_range(15);
        if (pick < 2)
            mag = '0;
        else if (pick == 2)
            mag = 16'hFFFF;
        else if (pick < 5)
            mag = cfg_bin_thr + 16'($urandom_range(4)) - 16'd2;
        else
            mag = 16'($urandom_range(65535) >> frame_shift);
        return mag;
    endfunction

    // one bin beat; idle gaps ahead of it as the current mode asks
    task automatic send_bin(input logic [15:0] mag, input bit typed, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mag;
        do @(posedge aclk); while (!s_tready);
        bins_sent++;
        if (octave_step(mag, predicted))
            band_results_due.push_back(typed ? want : predicted);
    endtask

    // block idle: every band beat back, back end settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (band_results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        case (addr)
            REG_PEAK_DECAY:     cfg_decay    = data[7:0];
            REG_LOUDNESS_FLOOR: cfg_floor    = data[7:0];
            REG_BIN_THRESHOLD:  cfg_bin_thr  = data[15:0];
            REG_BEAT_THRESHOLD: cfg_beat_thr = data[11:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(input int sidle, input int rstall,
                             input logic [7:0] decay, input logic [7:0] floor_val,
                             input logic [15:0] bin_thr, input logic [11:0] beat_thr,
                             input int count, input bit squeeze);
        int i;
        wait_idle();
        write_reg(REG_PEAK_DECAY,     16'(decay));
        write_reg(REG_LOUDNESS_FLOOR, 16'(floor_val));
        write_reg(REG_BIN_THRESHOLD,  bin_thr);
        write_reg(REG_BEAT_THRESHOLD, 16'(beat_thr));
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        for (i = 0; i < count; i++) begin
            // long output hold while bins keep coming: band queue fills up
            if (squeeze && i == 40)
                hold_requests++;
            send_bin(rand_mag(), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report(input string what, input int unsigned got,
                          input int unsigned want);
        $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_band(input result_t seen);
        result_t due;
        if (band_results_due.size() == 0) begin
            report("band beat with nothing pending, band", seen.band_number, 0);
            return;
        end
        due = band_results_due.pop_front();
        if (seen.band_number != due.band_number)
            report("band_number", seen.band_number, due.band_number);
        if (seen.band_level != due.band_level)
            report("band_level", seen.band_level, due.band_level);
        if (seen.band_peak != due.band_peak)
            report("band_peak", seen.band_peak, due.band_peak);
        if (seen.peak_new != due.peak_new)
            report("peak_new", seen.peak_new, due.peak_new);
        if (seen.frame_done != due.frame_done)
            report("frame_done", seen.frame_done, due.frame_done);
        if (seen.loudness_scaled != due.loudness_scaled)
            report("loudness_scaled", seen.loudness_scaled, due.loudness_scaled);
        if (seen.loudness_smooth != due.loudness_smooth)
            report("loudness_smooth", seen.loudness_smooth, due.loudness_smooth);
        if (seen.beat_flag != due.beat_flag)
            report("beat_flag", seen.beat_flag, due.beat_flag);
        bands_checked++;
        frames_seen += due.frame_done;
        beats_seen  += due.beat_flag;
        new_peaks   += due.peak_new;
    endtask

    // result side: sample at the edge, then pick tready for the next cycle
    initial begin : result_sink
        result_t seen;
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                seen.band_number     = m_tdata[3:0];
                seen.band_level      = m_tdata[15:4];
                seen.band_peak       = m_tdata[27:16];
                seen.peak_new        = m_tdata[28];
                seen.loudness_scaled = m_tdata[36:29];
                seen.loudness_smooth = m_tdata[44:37];
                seen.beat_flag       = m_tdata[45];
                seen.frame_done      = m_tlast;
                check_band(seen);
            end
            if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ends the run after too many cycles with no beat and no register write
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without progress", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        dir_row_t dir_rows[$];
        int n;

        // Frame 1 from reset: silent frame, zero loudness maximum.
        // Bins 0 and 1 are skipped even at full scale.
        dir_rows.push_back(bin_row(16'hFFFF, 2));
        dir_rows.push_back(checked_row(16'd0, 1,  0, 0, 0, 1'b0, 1'b0));
        dir_rows.push_back(checked_row(16'd0, 2,  1, 0, 0, 1'b0, 1'b0));
        dir_rows.push_back(checked_row(16'd0, 4,  2, 0, 0, 1'b0, 1'b0));
        dir_rows.push_back(checked_row(16'd0, 8,  3, 0, 0, 1'b0, 1'b0));
        dir_rows.push_back(checked_row(16'd0, 15, 4, 0, 0, 1'b0, 1'b1));
        // Frame 2: full scale bin, bins equal to threshold, one step above
        dir_rows.push_back(bin_row(16'd0, 2));
        dir_rows.push_back(checked_row(16'hFFFF, 1, 0, 4095, 4095, 1'b1, 1'b0));
        dir_rows.push_back(checked_row(16'd1500, 2, 1, 0, 0, 1'b0, 1'b0));
        dir_rows.push_back(checked_row(16'd1501, 4, 2, 93, 93, 1'b1, 1'b0));
        dir_rows.push_back(bin_row(16'd40000, 8));
        dir_rows.push_back(bin_row(16'd0, 15));
        // register extremes between frames
        dir_rows.push_back(cfg_row(REG_PEAK_DECAY, 16'd255));
        dir_rows.push_back(cfg_row(REG_BIN_THRESHOLD, 16'd0));
        dir_rows.push_back(cfg_row(REG_BEAT_THRESHOLD, 16'd0));
        dir_rows.push_back(cfg_row(REG_LOUDNESS_FLOOR, 16'd255));
        // Frame 3: counted bin below 16 scales to zero, threshold change mid-frame
        dir_rows.push_back(bin_row(16'd0, 2));
        dir_rows.push_back(bin_row(16'd1, 1));
        dir_rows.push_back(bin_row(16'hFFFF, 2));
        dir_rows.push_back(bin_row(16'd16, 3));
        dir_rows.push_back(cfg_row(REG_BIN_THRESHOLD, 16'hFFFF));
        dir_rows.push_back(bin_row(16'hFFFF, 1));
        dir_rows.push_back(bin_row(16'hFFFF, 8));
        dir_rows.push_back(bin_row(16'd4095, 15));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_rows[i].addr, dir_rows[i].value);
            end else begin
                for (n = 0; n < dir_rows[i].reps; n++)
                    send_bin(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // random frames: idle and stall mode, registers, bin count, output hold
        run_phase(0,  0,  8'd1,   8'd0,   16'd1500,  12'd30,   200, 1'b0);
        run_phase(67, 0,  8'd255, 8'd255, 16'd0,     12'd0,    150, 1'b0);
        run_phase(0,  67, 8'd0,   8'd0,   16'hFFFF,  12'd4095, 100, 1'b0);
        run_phase(13, 13, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(65535) >> $urandom_range(6)),
                  12'($urandom_range(4095) >> $urandom_range(8)), 250, 1'b0);
        run_phase(0,  0,  8'd7,   8'd40,  16'd800,   12'd100,  200, 1'b1);
        run_phase(67, 67, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(65535) >> $urandom_range(6)),
                  12'($urandom_range(4095) >> $urandom_range(8)), 150, 1'b0);
        run_phase(0,  0,  8'($urandom_range(32)), 8'($urandom_range(64)),
                  16'($urandom_range(4000)), 12'($urandom_range(200)), 200, 1'b0);

        wait_idle();

        $display("Covered %0d bins, %0d band beats in %0d frames (%0d new peaks, %0d beats)",
                 bins_sent, bands_checked, frames_seen, new_peaks, beats_seen);
        $display("Idle and stall mixes, a %0d-cycle output hold, registers 0 to full scale",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/obl_pkg.sv
rtl/obl_front.sv
rtl/obl_fifo.sv
rtl/obl_div.sv
rtl/obl_back.sv
rtl/octave_band_level_peak_loudness.sv
tb/sv/octave_band_level_peak_loudness_test.sv
